[rtl/srsim_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srsim_pkg
// Shared types and constants for the sorted range set insert/merge block.
// ----------------------------------------------------------------------------
package srsim_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_RANGES_DEF = 16;
  localparam int ADDR_WIDTH_DEF = 32;

  // Fixed field widths on the item channels
  localparam int ADDR_FIELD_W = 32;
  localparam int STATUS_W     = 2;
  localparam int SLOT_W       = 4;
  localparam int COUNT_W      = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_MERGED   = 2'd1,
    ST_INVALID  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Scan pointer operation
  typedef enum logic [1:0] {
    P_HOLD,
    P_CLR,
    P_INC
  } p_op_t;

  // Table read address select
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_PNEXT,
    RD_SRC,
    RD_SRC_DN
  } rd_sel_t;

  // Table write select
  typedef enum logic [1:0] {
    WR_NONE,
    WR_MERGE,
    WR_NEW,
    WR_PEND
  } wr_sel_t;

  typedef struct packed {
    logic    load;
    p_op_t   p_op;
    logic    hit_merge;
    logic    hit_insert;
    logic    le_take;
    logic    copy_init;
    logic    step_up;
    logic    step_dn;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    finish;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic invalid;
    logic p_at_n;
    logic below;
    logic touch;
    logic full;
    logic no_removed;
    logic src_at_n;
    logic src_at_i;
    logic wpend;
    logic out_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

[rtl/srsim_ifs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srsim item channels
// Valid/ready channels for range items in and result items out.
// ----------------------------------------------------------------------------
interface srsim_in_if;
  import srsim_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ADDR_FIELD_W-1:0] range_start;
  logic [ADDR_FIELD_W-1:0] range_end;

  modport source (output valid, output range_start, output range_end, input ready);
  modport sink   (input valid, input range_start, input range_end, output ready);
endinterface

interface srsim_out_if;
  import srsim_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [ADDR_FIELD_W-1:0] result_start;
  logic [ADDR_FIELD_W-1:0] result_end;
  logic [SLOT_W-1:0]       slot_index;
  logic [COUNT_W-1:0]      range_count;

  modport source (output valid, output status, output result_start, output result_end,
                  output slot_index, output range_count, input ready);
  modport sink   (input valid, input status, input result_start, input result_end,
                  input slot_index, input range_count, output ready);
endinterface
`default_nettype wire

[rtl/srsim_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srsim_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srsim_ram #(
  parameter int WIDTH = 2 * srsim_pkg::ADDR_WIDTH_DEF,
  parameter int DEPTH = srsim_pkg::MAX_RANGES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/srsim_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srsim_dp
// Datapath: range table RAM, scan and copy pointers, compares, result register.
// ----------------------------------------------------------------------------
module srsim_dp #(
  parameter int MAX_RANGES = srsim_pkg::MAX_RANGES_DEF,
  parameter int ADDR_WIDTH = srsim_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [srsim_pkg::ADDR_FIELD_W-1:0]    range_start,
  input  logic [srsim_pkg::ADDR_FIELD_W-1:0]    range_end,
  input  srsim_pkg::dp_cmd_t                    cmd,
  output srsim_pkg::dp_sts_t                    sts,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [srsim_pkg::STATUS_W-1:0]        status,
  output logic [srsim_pkg::ADDR_FIELD_W-1:0]    result_start,
  output logic [srsim_pkg::ADDR_FIELD_W-1:0]    result_end,
  output logic [srsim_pkg::SLOT_W-1:0]          slot_index,
  output logic [srsim_pkg::COUNT_W-1:0]         range_count
);
  import srsim_pkg::*;

  localparam int AW = ADDR_WIDTH;
  localparam int CW = $clog2(MAX_RANGES + 1);
  localparam int IW = $clog2(MAX_RANGES);
  localparam int DW = 2 * AW;

  logic [AW-1:0] ns;
  logic [AW-1:0] ne;
  logic [AW-1:0] ms;
  logic [AW-1:0] le;
  logic [CW-1:0] n;
  logic [CW-1:0] p;
  logic [CW-1:0] i_slot;
  logic [CW-1:0] src;
  logic [CW-1:0] dst;
  logic          wpend;
  logic [IW-1:0] wpend_addr;

  logic          we;
  logic [IW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [IW-1:0] raddr;
  logic [DW-1:0] rdata;
  logic [CW-1:0] rd_idx;

  logic [AW-1:0] rd_start;
  logic [AW-1:0] rd_end;
  logic [AW:0]   ne1;
  logic [AW-1:0] me;
  logic [AW-1:0] ms_pick;
  logic [CW:0]   cnt_merge;
  logic [CW-1:0] cnt_new;

  logic [AW-1:0] res_start;
  logic [AW-1:0] res_end;
  logic [CW-1:0] res_slot;

  logic [AW+ADDR_FIELD_W-1:0] in_s_ext;
  logic [AW+ADDR_FIELD_W-1:0] in_e_ext;
  logic [AW+ADDR_FIELD_W-1:0] rs_ext;
  logic [AW+ADDR_FIELD_W-1:0] re_ext;
  logic [CW+SLOT_W-1:0]       slot_ext;
  logic [CW+COUNT_W-1:0]      cnt_ext;

  srsim_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_start = rdata[DW-1:AW];
  assign rd_end   = rdata[AW-1:0];

  // Input fields taken modulo 2^AW
  assign in_s_ext = {AW'(0), range_start};
  assign in_e_ext = {AW'(0), range_end};

  // One bit wider so end + 1 at the top address does not wrap
  assign ne1     = {1'b0, ne} + (AW + 1)'(1);
  assign me      = (le > ne) ? le : ne;
  assign ms_pick = (rd_start < ns) ? rd_start : ns;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_ZERO:   rd_idx = '0;
      RD_PNEXT:  rd_idx = p + CW'(1);
      RD_SRC:    rd_idx = src;
      RD_SRC_DN: rd_idx = src - CW'(1);
      default:   rd_idx = '0;
    endcase
  end
  assign raddr = rd_idx[IW-1:0];

  always_comb begin
    we    = 1'b1;
    waddr = i_slot[IW-1:0];
    wdata = {ns, ne};
    unique case (cmd.wr_sel)
      WR_NONE:  we = 1'b0;
      WR_MERGE: wdata = {ms, me};
      WR_NEW:   wdata = {ns, ne};
      WR_PEND: begin
        waddr = wpend_addr;
        wdata = rdata;
      end
      default:  we = 1'b0;
    endcase
  end

  // Merge keeps slot i and drops the (p - i - 1) ranges it swallowed
  assign cnt_merge = {1'b0, n} + {1'b0, i_slot} + (CW + 1)'(1) - {1'b0, p};

  always_comb begin
    unique case (cmd.code)
      ST_INSERTED: begin
        cnt_new   = n + CW'(1);
        res_start = ns;
        res_end   = ne;
        res_slot  = i_slot;
      end
      ST_MERGED: begin
        cnt_new   = cnt_merge[CW-1:0];
        res_start = ms;
        res_end   = me;
        res_slot  = i_slot;
      end
      ST_INVALID: begin
        cnt_new   = n;
        res_start = '0;
        res_end   = '0;
        res_slot  = '0;
      end
      ST_FULL: begin
        cnt_new   = n;
        res_start = ns;
        res_end   = ne;
        res_slot  = '0;
      end
      default: begin
        cnt_new   = n;
        res_start = '0;
        res_end   = '0;
        res_slot  = '0;
      end
    endcase
  end

  assign rs_ext   = {ADDR_FIELD_W'(0), res_start};
  assign re_ext   = {ADDR_FIELD_W'(0), res_end};
  assign slot_ext = {SLOT_W'(0), res_slot};
  assign cnt_ext  = {COUNT_W'(0), cnt_new};

  assign sts.invalid    = ns > ne;
  assign sts.p_at_n     = p == n;
  assign sts.below      = ne1 < {1'b0, rd_start};
  assign sts.touch      = {1'b0, ns} <= ({1'b0, rd_end} + (AW + 1)'(1));
  assign sts.full       = n == CW'(MAX_RANGES);
  assign sts.no_removed = p == (i_slot + CW'(1));
  assign sts.src_at_n   = src == n;
  assign sts.src_at_i   = src == i_slot;
  assign sts.wpend      = wpend;
  assign sts.out_busy   = out_valid && !out_ready;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      n         <= '0;
      wpend     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      wpend <= cmd.step_up | cmd.step_dn;
      if (cmd.finish) begin
        out_valid <= 1'b1;
        n         <= cnt_new;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ns <= in_s_ext[AW-1:0];
      ne <= in_e_ext[AW-1:0];
    end
    unique case (cmd.p_op)
      P_HOLD:  p <= p;
      P_CLR:   p <= '0;
      P_INC:   p <= p + CW'(1);
      default: p <= p;
    endcase
    if (cmd.hit_merge) begin
      i_slot <= p;
      ms     <= ms_pick;
      le     <= rd_end;
    end
    if (cmd.hit_insert) begin
      i_slot <= p;
      src    <= n;
    end
    if (cmd.le_take) begin
      le <= rd_end;
    end
    if (cmd.copy_init) begin
      src <= p;
      dst <= i_slot + CW'(1);
    end
    if (cmd.step_up) begin
      src        <= src + CW'(1);
      dst        <= dst + CW'(1);
      wpend_addr <= dst[IW-1:0];
    end
    if (cmd.step_dn) begin
      src        <= src - CW'(1);
      wpend_addr <= src[IW-1:0];
    end
    if (cmd.finish) begin
      status       <= cmd.code;
      result_start <= rs_ext[ADDR_FIELD_W-1:0];
      result_end   <= re_ext[ADDR_FIELD_W-1:0];
      slot_index   <= slot_ext[SLOT_W-1:0];
      range_count  <= cnt_ext[COUNT_W-1:0];
    end
  end
endmodule
`default_nettype wire

[rtl/srsim_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srsim_ctrl
// Sequencer: check, scan, merge/compact or shift/insert, then post result.
// ----------------------------------------------------------------------------
module srsim_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srsim_pkg::dp_sts_t  sts,
  output srsim_pkg::dp_cmd_t  cmd
);
  import srsim_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_MSCAN,
    S_MCOPY,
    S_ISHIFT,
    S_DONE
  } state_t;

  state_t  state;
  state_t  state_next;
  status_t code;
  status_t code_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    cmd.code   = code;
    state_next = state;
    code_next  = code;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.invalid) begin
          code_next  = ST_INVALID;
          state_next = S_DONE;
        end else begin
          cmd.p_op   = P_CLR;
          cmd.rd_sel = RD_ZERO;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.p_at_n || sts.below) begin
          if (sts.full) begin
            code_next  = ST_FULL;
            state_next = S_DONE;
          end else begin
            cmd.hit_insert = 1'b1;
            code_next      = ST_INSERTED;
            state_next     = S_ISHIFT;
          end
        end else if (sts.touch) begin
          cmd.hit_merge = 1'b1;
          cmd.p_op      = P_INC;
          cmd.rd_sel    = RD_PNEXT;
          code_next     = ST_MERGED;
          state_next    = S_MSCAN;
        end else begin
          cmd.p_op   = P_INC;
          cmd.rd_sel = RD_PNEXT;
        end
      end
      S_MSCAN: begin
        // p stops on the first range the merged range does not reach
        if (sts.p_at_n || sts.below) begin
          cmd.wr_sel    = WR_MERGE;
          cmd.copy_init = 1'b1;
          state_next    = sts.no_removed ? S_DONE : S_MCOPY;
        end else begin
          cmd.le_take = 1'b1;
          cmd.p_op    = P_INC;
          cmd.rd_sel  = RD_PNEXT;
        end
      end
      S_MCOPY: begin
        if (!sts.src_at_n) begin
          cmd.step_up = 1'b1;
          cmd.rd_sel  = RD_SRC;
        end
        if (sts.wpend) begin
          cmd.wr_sel = WR_PEND;
        end
        if (sts.src_at_n && !sts.wpend) begin
          state_next = S_DONE;
        end
      end
      S_ISHIFT: begin
        if (!sts.src_at_i) begin
          cmd.step_dn = 1'b1;
          cmd.rd_sel  = RD_SRC_DN;
        end
        if (sts.wpend) begin
          cmd.wr_sel = WR_PEND;
        end
        if (sts.src_at_i && !sts.wpend) begin
          cmd.wr_sel = WR_NEW;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_INVALID;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end
endmodule
`default_nettype wire

[rtl/sorted_range_set_insert_merge.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_range_set_insert_merge
// Ordered table of disjoint inclusive address ranges with merge on insert.
// ----------------------------------------------------------------------------
// Each item on range_item offers one inclusive range. The block keeps up to
// MAX_RANGES ranges in ascending order, never overlapping or touching. An
// offered range with start above end is ignored (status 2, zero fields). A
// range that overlaps or touches stored ranges absorbs them into one slot
// (status 1); otherwise it is inserted in order (status 0), or dropped with
// status 3 if the table is full. Exactly one result item comes out per item,
// carrying the range as stored, its slot and the new range count. Items are
// handled one at a time: range_item.ready is high only while the block is
// idle. The table sits in one RAM with a single read and a single write
// port, walked one entry per cycle: the scan over the stored entries, then
// the shift-up on insert or the compaction after a merge that absorbed
// more than one range. The finished result sits in an output register, so
// a stalled result_item only holds the next result back at its final step.
// Table contents are not cleared at reset; only the count is.
// ----------------------------------------------------------------------------
module sorted_range_set_insert_merge #(
  parameter int MAX_RANGES = srsim_pkg::MAX_RANGES_DEF,
  parameter int ADDR_WIDTH = srsim_pkg::ADDR_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  srsim_in_if.sink    range_item,
  srsim_out_if.source result_item
);
  import srsim_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    ctrl_ready;

  // Sequencer: owns the item handshake and walks the table
  srsim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (range_item.valid),
    .in_ready (ctrl_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign range_item.ready = ctrl_ready;

  // Table RAM, compares and the result register
  srsim_dp #(
    .MAX_RANGES (MAX_RANGES),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .range_start  (range_item.range_start),
    .range_end    (range_item.range_end),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (result_item.ready),
    .out_valid    (result_item.valid),
    .status       (result_item.status),
    .result_start (result_item.result_start),
    .result_end   (result_item.result_end),
    .slot_index   (result_item.slot_index),
    .range_count  (result_item.range_count)
  );
endmodule
`default_nettype wire

[tb/sorted_range_set_insert_merge_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_range_set_insert_merge_tb
// Self-checking bench for the sorted range set with merge on insert.
// ----------------------------------------------------------------------------
// A mirror of the range table predicts every result item as each range item
// is accepted. Results are checked field by field, in order, against that
// prediction. The run has directed phases first: ignored ranges, insert and
// merge on both sides, the top address, a full table, and a long output
// stall. A random phase follows. It works in address windows carved out of
// the largest free gap, so inserts, merges, touches and table-full drops all
// happen often. Between windows, the closest pairs are merged to keep room.
// ----------------------------------------------------------------------------
module sorted_range_set_insert_merge_tb;
  import srsim_pkg::*;

  localparam int TABLE_DEPTH  = MAX_RANGES_DEF;
  localparam int ADDR_W       = ADDR_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1250;
  // Worst item: full scan plus full shift.
  localparam int DRAIN_CYCLES = 64;
  localparam int LONG_HOLD    = 400;
  // Quietest correct stretch: the long hold, one slow item and a sender gap.
  // Taken several times over.
  localparam int WATCHDOG     = 4000;

  typedef struct packed {
    status_t                 status;
    logic [ADDR_FIELD_W-1:0] first;
    logic [ADDR_FIELD_W-1:0] last;
    logic [SLOT_W-1:0]       slot;
    logic [COUNT_W-1:0]      count;
  } range_result_t;

  logic clk = 1'b0;
  logic rst;

  srsim_in_if  range_if ();
  srsim_out_if result_if ();

  sorted_range_set_insert_merge #(
    .MAX_RANGES(TABLE_DEPTH),
    .ADDR_WIDTH(ADDR_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .range_item(range_if),
    .result_item(result_if)
  );

  always #5 clk = ~clk;

  // Mirror of the table. Only entries below range_cnt are meaningful.
  logic [ADDR_W-1:0] range_lo [TABLE_DEPTH];
  logic [ADDR_W-1:0] range_hi [TABLE_DEPTH];
  int                range_cnt = 0;

  range_result_t pending_results [$];
  int            mismatch_count = 0;
  int            valid_sent = 0;
  int            burst_left = 0;
  int            idle_cycles = 0;
  logic          hold_active;
  event          hold_off_ev;

  // --------------------------------------------------------------------------
  // Table mirror: apply one offered range, return the result it must produce.
  // Address math runs one bit wider so end + 1 at the top address cannot wrap.
  // --------------------------------------------------------------------------
  function automatic range_result_t apply_range(logic [ADDR_FIELD_W-1:0] in_start,
                                                logic [ADDR_FIELD_W-1:0] in_end);
    logic [ADDR_W:0] ns, ne, ne_next, last_end, ms, me;
    int              pos, j, k, absorbed;
    bit              found, merged;
    range_result_t   res;
    ns = {1'b0, in_start[ADDR_W-1:0]};
    ne = {1'b0, in_end[ADDR_W-1:0]};
    ne_next = ne + 1'b1;
    res = '0;
    found = 1'b0;
    merged = 1'b0;
    pos = range_cnt;
    if (ns > ne) begin
      // ignored: zero fields, table untouched
      res.status = ST_INVALID;
      res.count = range_cnt[COUNT_W-1:0];
      return res;
    end
    for (k = 0; k < range_cnt && !found; k++) begin
      if (ne_next < {1'b0, range_lo[k]}) begin
        pos = k;
        found = 1'b1;
      end else if (ns <= {1'b0, range_hi[k]} + 1'b1) begin
        pos = k;
        found = 1'b1;
        merged = 1'b1;
      end
    end
    if (merged) begin
      // absorb every following entry that starts at or below new end + 1
      j = pos + 1;
      last_end = {1'b0, range_hi[pos]};
      while (j < range_cnt && !(ne_next < {1'b0, range_lo[j]})) begin
        last_end = {1'b0, range_hi[j]};
        j++;
      end
      me = (last_end > ne) ? last_end : ne;
      ms = ({1'b0, range_lo[pos]} < ns) ? {1'b0, range_lo[pos]} : ns;
      absorbed = j - pos - 1;
      range_lo[pos] = ms[ADDR_W-1:0];
      range_hi[pos] = me[ADDR_W-1:0];
      for (k = pos + 1; k + absorbed < range_cnt; k++) begin
        range_lo[k] = range_lo[k + absorbed];
        range_hi[k] = range_hi[k + absorbed];
      end
      range_cnt = range_cnt - absorbed;
      res.status = ST_MERGED;
      res.first = ms[ADDR_W-1:0];
      res.last = me[ADDR_W-1:0];
      res.slot = pos[SLOT_W-1:0];
    end else if (range_cnt >= TABLE_DEPTH) begin
      // full and nothing to merge with: dropped, offered range echoed
      res.status = ST_FULL;
      res.first = ns[ADDR_W-1:0];
      res.last = ne[ADDR_W-1:0];
    end else begin
      for (k = range_cnt; k > pos; k--) begin
        range_lo[k] = range_lo[k - 1];
        range_hi[k] = range_hi[k - 1];
      end
      range_lo[pos] = ns[ADDR_W-1:0];
      range_hi[pos] = ne[ADDR_W-1:0];
      range_cnt++;
      res.status = ST_INSERTED;
      res.first = ns[ADDR_W-1:0];
      res.last = ne[ADDR_W-1:0];
      res.slot = pos[SLOT_W-1:0];
    end
    res.count = range_cnt[COUNT_W-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one range item, in bursts with random gaps in between. The
  // prediction is taken at the accepting edge, so callers always see the
  // table as it stands after their last item.
  // --------------------------------------------------------------------------
  task automatic send_range(input logic [ADDR_FIELD_W-1:0] first,
                            input logic [ADDR_FIELD_W-1:0] last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        range_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    range_if.valid <= 1'b1;
    range_if.range_start <= first;
    range_if.range_end <= last;
    @(posedge clk);
    while (!range_if.ready) @(posedge clk);
    pending_results.push_back(apply_range(first, last));
    valid_sent++;
  endtask

  // start > end with every bit free to move
  task automatic send_reversed_noise();
    logic [ADDR_FIELD_W-1:0] a, b;
    a = $urandom;
    b = $urandom;
    if (a == b) b = a ^ 1;
    if (a > b) send_range(a, b);
    else send_range(b, a);
  endtask

  // Merge the two stored neighbors with the narrowest gap until the count
  // is down to the target. Each step is one merge that absorbs one entry.
  task automatic merge_closest_pairs(input int target);
    longint unsigned best_gap, this_gap;
    int              best_idx, idx;
    while (range_cnt > target && range_cnt > 1) begin
      best_gap = 64'hFFFF_FFFF_FFFF_FFFF;
      best_idx = 0;
      for (idx = 0; idx + 1 < range_cnt; idx++) begin
        this_gap = {32'b0, range_lo[idx + 1]} - {32'b0, range_hi[idx]};
        if (this_gap < best_gap) begin
          best_gap = this_gap;
          best_idx = idx;
        end
      end
      send_range(range_lo[best_idx], range_hi[best_idx + 1]);
    end
  endtask

  // Ranges that start right above or end right below a stored entry.
  task automatic send_touching_range();
    longint unsigned s64, e64;
    int              idx, len;
    idx = $urandom_range(0, range_cnt - 1);
    len = $urandom_range(0, 15);
    if ($urandom_range(0, 1) == 1 && range_hi[idx] != '1) begin
      s64 = {32'b0, range_hi[idx]} + 1;
      e64 = s64 + len;
      if (e64 > 64'hFFFF_FFFF) e64 = 64'hFFFF_FFFF;
      send_range(s64[31:0], e64[31:0]);
    end else if (range_lo[idx] != '0) begin
      e64 = {32'b0, range_lo[idx]} - 1;
      s64 = (e64 >= len) ? e64 - len : 0;
      send_range(s64[31:0], e64[31:0]);
    end
  endtask

  // --------------------------------------------------------------------------
  // One random window: place it in the largest free gap, throw ranges at it,
  // then usually sweep the whole window so it collapses into one entry.
  // --------------------------------------------------------------------------
  task automatic run_window_episode();
    longint unsigned cursor, gap_lo, gap_size, span, wb, ws, off, s64, e64;
    int              idx, kind, n_items;
    cursor = 0;
    gap_lo = 0;
    gap_size = 0;
    for (idx = 0; idx < range_cnt; idx++) begin
      if ({32'b0, range_lo[idx]} > cursor &&
          {32'b0, range_lo[idx]} - cursor > gap_size) begin
        gap_lo = cursor;
        gap_size = {32'b0, range_lo[idx]} - cursor;
      end
      cursor = {32'b0, range_hi[idx]} + 1;
    end
    if (64'h1_0000_0000 - cursor > gap_size) begin
      gap_lo = cursor;
      gap_size = 64'h1_0000_0000 - cursor;
    end
    if (gap_size < 2) begin
      // no free room left: everything merges now
      send_range($urandom, 32'hFFFF_FFFF);
      return;
    end
    ws = ($urandom_range(0, 7) == 0) ? $urandom_range(4096, 1 << 20)
                                     : $urandom_range(32, 1024);
    if (ws > gap_size) ws = gap_size;
    span = gap_size - ws;
    // half the time hug the low edge of the gap so address space lasts the run
    if ($urandom_range(0, 1) == 1) begin
      off = $urandom_range(0, 4096);
      if (off > span) off = span;
    end else begin
      off = {$urandom, $urandom} % (span + 1);
    end
    wb = gap_lo + off;
    n_items = $urandom_range(4, 40);
    repeat (n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        s64 = wb + ({32'b0, $urandom} % ws);
        e64 = s64 + (($urandom_range(0, 9) == 0) ? ({32'b0, $urandom} % ws)
                                                  : $urandom_range(0, 7));
        if (e64 > wb + ws - 1) e64 = wb + ws - 1;
        send_range(s64[31:0], e64[31:0]);
      end else if (kind < 82 && range_cnt > 0) begin
        send_touching_range();
      end else if (kind < 97) begin
        send_reversed_noise();
      end else begin
        // stray range anywhere in the space
        s64 = {32'b0, $urandom};
        e64 = s64 + $urandom_range(0, 255);
        if (e64 > 64'hFFFF_FFFF) e64 = 64'hFFFF_FFFF;
        send_range(s64[31:0], e64[31:0]);
      end
    end
    if ($urandom_range(0, 4) != 0) begin
      e64 = wb + ws - 1;
      send_range(wb[31:0], e64[31:0]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_invalid_ranges();
    send_range(32'h0000_0001, 32'h0000_0000);
    send_range(32'hFFFF_FFFF, 32'h0000_0000);
    send_range(32'h8000_0000, 32'h7FFF_FFFF);
  endtask

  task automatic test_insert_and_merge();
    send_range(32'h0000_1000, 32'h0000_10FF);  // into the empty table
    send_range(32'h0000_3000, 32'h0000_30FF);  // append
    send_range(32'h0000_0100, 32'h0000_01FF);  // insert below all
    send_range(32'h0000_1100, 32'h0000_11FF);  // touches end + 1 of a stored one
    send_range(32'h0000_0F00, 32'h0000_0FFF);  // touches its start from below
    send_range(32'h0000_2000, 32'h0000_2FFE);  // one short of touching above
    // absorbs several; last absorbed end beats the new end
    send_range(32'h0000_0150, 32'h0000_2F00);
  endtask

  task automatic test_top_address();
    send_range(32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'hFFFF_FEF0, 32'hFFFF_FEFF);
    send_range(32'h0000_0000, 32'h0000_0000);  // top end + 1 must not wrap here
  endtask

  task automatic test_full_table();
    logic [ADDR_FIELD_W-1:0] base;
    int                      k;
    base = 32'h0001_0000;
    k = 0;
    while (range_cnt < TABLE_DEPTH) begin
      send_range(base + 4 * k, base + 4 * k + 1);
      k++;
    end
    send_range(32'h8000_0000, 32'h8000_0000);  // no merge: dropped
    send_range(base + 2, base + 2);            // merge still works when full
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering;
  // the items double as cleanup of the full table.
  task automatic test_output_stall();
    -> hold_off_ev;
    send_reversed_noise();
    merge_closest_pairs(4);
    send_reversed_noise();
  endtask

  task automatic test_random_ranges();
    valid_sent = 0;
    while (valid_sent < RANDOM_ITEMS) begin
      merge_closest_pairs($urandom_range(1, 12));
      run_window_episode();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst <= 1'b1;
    range_if.valid <= 1'b0;
    range_if.range_start <= '0;
    range_if.range_end <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_invalid_ranges();
    test_insert_and_merge();
    test_top_address();
    test_full_table();
    test_output_stall();
    test_random_ranges();
    range_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // anything arriving now is an extra result and gets flagged
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: stall pattern switches between always ready, coin flip, mostly
  // stalled and a fixed one-in-three pattern. A long hold overrides it.
  // --------------------------------------------------------------------------
  initial begin
    hold_active <= 1'b0;
    forever begin
      @(hold_off_ev);
      @(posedge clk);
      hold_active <= 1'b1;
      repeat (LONG_HOLD) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  initial begin
    int stall_mode;
    int mode_left;
    int phase;
    bit rdy;
    stall_mode = 0;
    mode_left = 0;
    phase = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      phase++;
      case (stall_mode)
        0: begin
          rdy = 1'b1;
        end
        1: begin
          rdy = $urandom_range(0, 1);
        end
        2: begin
          rdy = ($urandom_range(0, 3) == 0);
        end
        default: begin
          rdy = (phase % 3 == 0);
        end
      endcase
      result_if.ready <= rdy && !hold_active;
    end
  end

  // --------------------------------------------------------------------------
  // Result check against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    range_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: status %0d start %h end %h",
               result_if.status, result_if.result_start, result_if.result_end);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result_if.status);
          mismatch_count++;
        end
        if (result_if.result_start !== want.first) begin
          $error("result_start: expected %h, got %h", want.first, result_if.result_start);
          mismatch_count++;
        end
        if (result_if.result_end !== want.last) begin
          $error("result_end: expected %h, got %h", want.last, result_if.result_end);
          mismatch_count++;
        end
        if (result_if.slot_index !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, result_if.slot_index);
          mismatch_count++;
        end
        if (result_if.range_count !== want.count) begin
          $error("range_count: expected %0d, got %0d", want.count, result_if.range_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (range_if.valid && range_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
`default_nettype wire
